[design/remote_control_frame_decoder_unit_defines.svh]
// Assertion macros for the remote control frame decoder RTL.
`ifndef REMOTE_CONTROL_FRAME_DECODER_UNIT_DEFINES_SVH
`define REMOTE_CONTROL_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clock and disabled during reset.
`define RCFD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock and disabled during reset.
`define RCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/rcfd_pkg.sv]
// Package with the types, codes and constants of the remote control frame decoder.
package rcfd_pkg;

   // Frame geometry and register reset values.
   localparam int FRAME_BYTES    = 18;
   localparam int MAX_COUNT_DEF  = 64;
   localparam int STORE_AW       = $clog2(FRAME_BYTES);
   localparam int CH_RAW_W       = 11;
   localparam int CH_W           = 12;
   localparam int NUM_CH         = 5;
   localparam int NUM_STICKS     = 4;
   localparam logic [CH_RAW_W-1:0] OFFSET_RESET = 11'd1024;
   localparam logic [CH_RAW_W-1:0] LIMIT_RESET  = 11'd660;

   // Request kind carried on tuser.
   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_IDLE = 1'b1
   } kind_type;

   // Result status carried on tuser.
   typedef enum logic [1:0] {
      ST_DECODED = 2'd0,
      ST_RANGE   = 2'd1,
      ST_LENGTH  = 2'd2
   } status_type;

   // Configuration register indexes.
   typedef enum logic {
      REG_OFFSET = 1'b0,
      REG_LIMIT  = 1'b1
   } reg_index_type;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_type;

   // Decoded frame handed from the decode logic to the top level.
   typedef struct packed {
      logic [NUM_CH-1:0][CH_W-1:0] channels;
      logic [1:0]                  switch_one;
      logic [1:0]                  switch_two;
      logic                        out_of_range;
   } decode_type;

endpackage

[design/rcfd_frame_store.sv]
// Frame byte store and saturating byte counter.
module rcfd_frame_store
   import rcfd_pkg::*;
#(
   parameter int MAX_COUNT = MAX_COUNT_DEF,
   parameter int CNT_W     = $clog2(MAX_COUNT + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_write,
   input  logic             count_clear,
   input  logic [7:0]       rx_byte,
   output frame_bytes_type  frame_bytes,
   output logic [CNT_W-1:0] byte_count
);

   frame_bytes_type  store_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // Each entry takes the byte when the count points at it.
   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (byte_write && (count_ff == CNT_W'(i))) begin
            store_ff[i] <= rx_byte;
         end
      end
   end

   // The count saturates at MAX_COUNT and restarts on a line idle event.
   always_comb begin
      count_in = count_ff;
      if (count_clear) begin
         count_in = '0;
      end else if (byte_write && (count_ff < CNT_W'(MAX_COUNT))) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign frame_bytes = store_ff;
   assign byte_count  = count_ff;

endmodule

[design/rcfd_decode.sv]
// Unpacks a stored frame into centered channels, switches and a range flag.
module rcfd_decode
   import rcfd_pkg::*;
(
   input  frame_bytes_type     frame_bytes,
   input  logic [CH_RAW_W-1:0] channel_offset,
   input  logic [CH_RAW_W-1:0] channel_limit,
   output decode_type          decoded
);

   logic [NUM_CH-1:0][CH_RAW_W-1:0] raw;
   logic [NUM_CH-1:0][CH_W-1:0]     centered;
   logic [NUM_STICKS-1:0]           over;

   // Raw 11-bit fields packed little endian: the four sticks across the first six bytes, the wheel in bytes 16 and 17.
   always_comb begin
      raw[0] = {frame_bytes[1][2:0], frame_bytes[0]};
      raw[1] = {frame_bytes[2][5:0], frame_bytes[1][7:3]};
      raw[2] = {frame_bytes[4][0], frame_bytes[3], frame_bytes[2][7:6]};
      raw[3] = {frame_bytes[5][3:0], frame_bytes[4][7:1]};
      raw[4] = {frame_bytes[17][2:0], frame_bytes[16]};
   end

   // Subtract the center and check each stick magnitude against the limit.
   always_comb begin
      logic [CH_W-1:0] mag;
      for (int i = 0; i < NUM_CH; i++) begin
         centered[i] = {1'b0, raw[i]} - {1'b0, channel_offset};
      end
      for (int i = 0; i < NUM_STICKS; i++) begin
         mag     = centered[i][CH_W-1] ? (CH_W'(0) - centered[i]) : centered[i];
         over[i] = (mag > {1'b0, channel_limit});
      end
   end

   assign decoded.channels     = centered;
   assign decoded.switch_one   = frame_bytes[5][7:6];
   assign decoded.switch_two   = frame_bytes[5][5:4];
   assign decoded.out_of_range = |over;

endmodule

[design/remote_control_frame_decoder_unit.sv]
// Top level of the remote control frame decoder: request stage, held values and result register.
// Each request is one received byte (tuser low) or a line idle event (tuser high). Requests are
// taken one per clock except during the stall below. A byte never produces a result. Each idle event
// produces exactly one result, which passes from the request register into the result register
// and carries the held channels, switches and a status. The only stall is an idle event that meets
// a result still waiting on rsp_tready. A byte is never held up by a waiting result, but it
// does wait behind a stalled idle event. The decode path sits between the frame store and the
// result register. Per channel it is one 12-bit subtract; per stick also a negate and a magnitude compare.
`include "remote_control_frame_decoder_unit_defines.svh"

module remote_control_frame_decoder_unit
   import rcfd_pkg::*;
#(
   parameter int MAX_COUNT = MAX_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] kind
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [11:0] stick_right_h, [23:12] stick_right_v,
                                    // [35:24] stick_left_h, [47:36] stick_left_v,
                                    // [59:48] wheel, [61:60] switch_one, [63:62] switch_two
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Configuration write port.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_COUNT + 1);

   logic                        req_valid_ff;
   kind_type                    req_kind_ff;
   logic [7:0]                  req_byte_ff;
   logic                        advance;
   logic                        byte_go;
   logic                        idle_go;
   logic [CH_RAW_W-1:0]         offset_ff;
   logic [CH_RAW_W-1:0]         limit_ff;
   frame_bytes_type             frame_bytes;
   logic [CNT_W-1:0]            byte_count;
   decode_type                  decoded;
   logic [NUM_CH-1:0][CH_W-1:0] held_ch_ff;
   logic [NUM_CH-1:0][CH_W-1:0] held_ch_in;
   logic [1:0]                  held_sw1_ff;
   logic [1:0]                  held_sw1_in;
   logic [1:0]                  held_sw2_ff;
   logic [1:0]                  held_sw2_in;
   status_type                  status_in;
   logic                        rsp_valid_ff;
   logic [63:0]                 rsp_data_ff;
   status_type                  rsp_status_ff;

   // A staged request moves on unless it is an idle event blocked by an untaken result.
   assign advance    = req_valid_ff
                       && ((req_kind_ff == KIND_BYTE) || !rsp_valid_ff || rsp_tready);
   assign byte_go    = advance && (req_kind_ff == KIND_BYTE);
   assign idle_go    = advance && (req_kind_ff == KIND_IDLE);
   assign req_tready = !req_valid_ff || advance;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_kind_ff <= kind_type'(req_tuser);
         req_byte_ff <= req_tdata;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_OFFSET: offset_ff <= csr_wdata;
            REG_LIMIT:  limit_ff  <= csr_wdata;
            default:    offset_ff <= offset_ff;
         endcase
      end
   end

   rcfd_frame_store #(
      .MAX_COUNT (MAX_COUNT),
      .CNT_W     (CNT_W)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .byte_write  (byte_go),
      .count_clear (idle_go),
      .rx_byte     (req_byte_ff),
      .frame_bytes (frame_bytes),
      .byte_count  (byte_count)
   );

   rcfd_decode u_decode (
      .frame_bytes    (frame_bytes),
      .channel_offset (offset_ff),
      .channel_limit  (limit_ff),
      .decoded        (decoded)
   );

   // Next held values and status for an idle event.
   always_comb begin
      held_ch_in  = held_ch_ff;
      held_sw1_in = held_sw1_ff;
      held_sw2_in = held_sw2_ff;
      status_in   = ST_LENGTH;
      if (byte_count == CNT_W'(FRAME_BYTES)) begin
         if (decoded.out_of_range) begin
            held_ch_in  = '0;
            held_sw1_in = '0;
            held_sw2_in = '0;
            status_in   = ST_RANGE;
         end else begin
            held_ch_in  = decoded.channels;
            held_sw1_in = decoded.switch_one;
            held_sw2_in = decoded.switch_two;
            status_in   = ST_DECODED;
         end
      end
   end

   // Held values update only on an idle event.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ch_ff  <= '0;
         held_sw1_ff <= '0;
         held_sw2_ff <= '0;
      end else if (idle_go) begin
         held_ch_ff  <= held_ch_in;
         held_sw1_ff <= held_sw1_in;
         held_sw2_ff <= held_sw2_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (idle_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (idle_go) begin
         rsp_data_ff   <= {held_sw2_in, held_sw1_in, held_ch_in};
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   `RCFD_ASSERT_NEXT(a_idle_gives_result, idle_go, rsp_valid_ff,
      "idle event did not load a result")
   `RCFD_ASSERT_NEXT(a_idle_clears_count, idle_go, byte_count == '0,
      "byte count not cleared after idle event")
   `RCFD_ASSERT_NOW(a_count_saturates, 1'b1, byte_count <= CNT_W'(MAX_COUNT),
      "byte count beyond its maximum")
   `RCFD_ASSERT_NOW(a_range_zeroes, rsp_valid_ff && (rsp_status_ff == ST_RANGE),
      rsp_data_ff == '0, "out of range result carries nonzero values")

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the remote control frame decoder: directed and random frames.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rcfd_pkg::*;

   localparam int ITEM_TARGET  = 650;
   localparam int REPORT_MIN   = 48;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 4;

   // One result as the block reports it: five held channels, two switches and a status.
   typedef struct packed {
      logic [NUM_CH-1:0][CH_W-1:0] ch;
      logic [1:0]                  sw_one;
      logic [1:0]                  sw_two;
      status_type                  status;
   } frame_report_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = 8'h00;
   kind_type      req_tuser = KIND_BYTE;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b1;
   logic [63:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          csr_we = 1'b0;
   reg_index_type csr_index = REG_OFFSET;
   logic [10:0]   csr_wdata = 11'd0;

   // Frame decoder predictor state.
   logic [7:0]         frame_mem [FRAME_BYTES];
   int                 rx_count;
   logic [CH_W-1:0]    held_ch [NUM_CH];
   logic [1:0]         held_sw_one;
   logic [1:0]         held_sw_two;
   int                 cfg_offset;
   int                 cfg_limit;
   frame_report_type   awaited_reports [$];

   // Stimulus side view of the registers and pacing.
   int  stim_offset = OFFSET_RESET;
   int  stim_limit  = LIMIT_RESET;
   bit  pace_on = 1'b1;
   int  rsp_stall = 0;
   int  accepted_requests = 0;
   int  reports_seen = 0;
   int  errors = 0;
   int  cycle_count = 0;

   string ch_name [NUM_CH] = '{"stick_right_h", "stick_right_v", "stick_left_h",
                               "stick_left_v", "wheel"};

   remote_control_frame_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Unpack the stored frame, subtract the offset and apply the stick range check.
   function automatic status_type decode_stored_frame();
      logic [10:0] raw [NUM_CH];
      int          centered [NUM_CH];
      int          mag;
      bit          out_of_range;
      raw[0] = {frame_mem[1][2:0], frame_mem[0]};
      raw[1] = {frame_mem[2][5:0], frame_mem[1][7:3]};
      raw[2] = {frame_mem[4][0], frame_mem[3], frame_mem[2][7:6]};
      raw[3] = {frame_mem[5][3:0], frame_mem[4][7:1]};
      raw[4] = {frame_mem[17][2:0], frame_mem[16]};
      out_of_range = 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
         centered[i] = int'(raw[i]) - cfg_offset;
         mag = centered[i] < 0 ? -centered[i] : centered[i];
         // The wheel is carried along but never range checked.
         if (i < NUM_STICKS && mag > cfg_limit) begin
            out_of_range = 1'b1;
         end
      end
      if (out_of_range) begin
         for (int i = 0; i < NUM_CH; i++) begin
            held_ch[i] = '0;
         end
         held_sw_one = 2'd0;
         held_sw_two = 2'd0;
         return ST_RANGE;
      end
      for (int i = 0; i < NUM_CH; i++) begin
         held_ch[i] = centered[i][CH_W-1:0];
      end
      held_sw_one = frame_mem[5][7:6];
      held_sw_two = frame_mem[5][5:4];
      return ST_DECODED;
   endfunction

   // Advance the predictor by one accepted request.
   function automatic void predict_request(kind_type kind, logic [7:0] data);
      frame_report_type rpt;
      status_type       st;
      if (kind == KIND_BYTE) begin
         // Bytes past the frame are only counted, and the count saturates.
         if (rx_count < FRAME_BYTES) begin
            frame_mem[rx_count] = data;
         end
         if (rx_count < MAX_COUNT_DEF) begin
            rx_count++;
         end
      end else begin
         st = (rx_count == FRAME_BYTES) ? decode_stored_frame() : ST_LENGTH;
         rx_count = 0;
         for (int i = 0; i < NUM_CH; i++) begin
            rpt.ch[i] = held_ch[i];
         end
         rpt.sw_one = held_sw_one;
         rpt.sw_two = held_sw_two;
         rpt.status = st;
         awaited_reports.push_back(rpt);
      end
   endfunction

   // Predictor update on register writes and accepted requests.
   always @(posedge clock) begin
      if (reset) begin
         rx_count = 0;
         for (int i = 0; i < NUM_CH; i++) begin
            held_ch[i] = '0;
         end
         held_sw_one = 2'd0;
         held_sw_two = 2'd0;
         cfg_offset = OFFSET_RESET;
         cfg_limit = LIMIT_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_OFFSET: cfg_offset = csr_wdata;
               REG_LIMIT: cfg_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            accepted_requests++;
            predict_request(req_tuser, req_tdata);
         end
      end
   end

   function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      frame_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports_seen++;
         if (awaited_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = awaited_reports.pop_front();
            for (int i = 0; i < NUM_CH; i++) begin
               check_field(ch_name[i], want.ch[i], rsp_tdata[CH_W*i +: CH_W]);
            end
            check_field("switch_one", 12'(want.sw_one), 12'(rsp_tdata[61:60]));
            check_field("switch_two", 12'(want.sw_two), 12'(rsp_tdata[63:62]));
            check_field("status", 12'(want.status), 12'(rsp_tuser));
         end
      end
   end

   // Result side back-pressure: a fresh stall length is drawn after every result.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_stall = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_stall = pace_on ? $urandom_range(0, 8) : 0;
         rsp_tready <= (rsp_stall == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= (rsp_stall == 0);
      end
   end

   // Drive one request and hold it until the block takes it.
   task automatic send_request(kind_type kind, logic [7:0] data);
      int gap;
      gap = pace_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop requesting and let every outstanding result drain.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(int offset_val, int limit_val);
      wait_for_quiet();
      stim_offset = offset_val;
      stim_limit = limit_val;
      csr_we <= 1'b1;
      csr_index <= REG_OFFSET;
      csr_wdata <= 11'(offset_val);
      @(posedge clock);
      csr_index <= REG_LIMIT;
      csr_wdata <= 11'(limit_val);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Place raw channels and switches into the frame layout; filler bytes are random.
   function automatic frame_bytes_type pack_frame(logic [NUM_CH-1:0][10:0] raw,
                                                  logic [1:0] s1, logic [1:0] s2);
      frame_bytes_type fb;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         fb[i] = 8'($urandom);
      end
      fb[0] = raw[0][7:0];
      fb[1] = {raw[1][4:0], raw[0][10:8]};
      fb[2] = {raw[2][1:0], raw[1][10:5]};
      fb[3] = raw[2][9:2];
      fb[4] = {raw[3][6:0], raw[2][10]};
      fb[5] = {s1, s2, raw[3][10:7]};
      fb[16] = raw[4][7:0];
      fb[17] = {fb[17][7:3], raw[4][10:8]};
      return fb;
   endfunction

   // Send count bytes (random past the frame) followed by the idle event.
   task automatic send_frame(frame_bytes_type fb, int count);
      for (int i = 0; i < count; i++) begin
         send_request(KIND_BYTE, i < FRAME_BYTES ? fb[i] : 8'($urandom));
      end
      send_request(KIND_IDLE, 8'($urandom));
   endtask

   // Pick a raw stick value inside the limit window, or just outside it.
   function automatic logic [10:0] stick_raw(bit outside);
      int d;
      int r;
      if (outside) begin
         d = stim_limit + 1 + $urandom_range(0, 300);
         if ($urandom_range(0, 1)) begin
            d = -d;
         end
      end else begin
         case ($urandom_range(0, 3))
            0: d = -stim_limit;
            1: d = stim_limit;
            default: d = int'($urandom_range(0, 2 * stim_limit)) - stim_limit;
         endcase
      end
      r = stim_offset + d;
      if (r < 0) begin
         r = 0;
      end
      if (r > 2047) begin
         r = 2047;
      end
      return r[10:0];
   endfunction

   function automatic logic [10:0] wheel_raw();
      case ($urandom_range(0, 3))
         0: return 11'd0;
         1: return 11'd2047;
         default: return 11'($urandom_range(0, 2047));
      endcase
   endfunction

   // One random frame: mostly well formed, some out of range, wrong length or noise.
   task automatic send_random_frame();
      logic [NUM_CH-1:0][10:0] raw;
      frame_bytes_type fb;
      int pick;
      int bad_ch;
      int count;
      pace_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      bad_ch = (pick >= 50 && pick < 65) ? $urandom_range(0, NUM_STICKS - 1) : -1;
      for (int i = 0; i < NUM_STICKS; i++) begin
         raw[i] = (pick >= 65 && pick < 75) ? 11'($urandom) : stick_raw(i == bad_ch);
      end
      raw[NUM_STICKS] = wheel_raw();
      fb = pack_frame(raw, 2'($urandom), 2'($urandom));
      if (pick < 75) begin
         send_frame(fb, FRAME_BYTES);
      end else if (pick < 90) begin
         count = $urandom_range(0, 34);
         if (count == FRAME_BYTES) begin
            count++;
         end
         send_frame(fb, count);
      end else if (pick < 95) begin
         send_frame(fb, $urandom_range(MAX_COUNT_DEF - 4, MAX_COUNT_DEF + 16));
      end else begin
         // A few requests of random kind and content.
         count = $urandom_range(1, 5);
         for (int i = 0; i < count; i++) begin
            send_request(kind_type'($urandom_range(0, 1)), 8'($urandom));
         end
      end
   endtask

   // Idle with nothing received, a frame at the window edges, and a short frame.
   task automatic test_directed();
      logic [NUM_CH-1:0][10:0] raw;
      pace_on = 1'b1;
      send_request(KIND_IDLE, 8'hFF);
      raw[0] = 11'(stim_offset - stim_limit);
      raw[1] = 11'(stim_offset + stim_limit);
      raw[2] = 11'(stim_offset);
      raw[3] = 11'(stim_offset - stim_limit);
      raw[4] = 11'd2047;
      send_frame(pack_frame(raw, 2'd3, 2'd0), FRAME_BYTES);
      send_request(KIND_BYTE, 8'h00);
      send_request(KIND_BYTE, 8'hFF);
      send_request(KIND_BYTE, 8'hA5);
      send_request(KIND_IDLE, 8'h00);
   endtask

   // Walk through register settings including both extremes of each register.
   task automatic test_config_sweep();
      int offsets [6] = '{0, 2047, 0, 2047, 1024, 0};
      int limits [6] = '{0, 2047, 2047, 0, 660, 0};
      offsets[5] = $urandom_range(0, 2047);
      limits[5] = $urandom_range(0, 2047);
      for (int k = 0; k < 6; k++) begin
         apply_setting(offsets[k], limits[k]);
         repeat (2) send_random_frame();
      end
   endtask

   // Frames with neither side pausing.
   task automatic test_back_to_back();
      logic [NUM_CH-1:0][10:0] raw;
      for (int f = 0; f < 4; f++) begin
         pace_on = 1'b0;
         for (int i = 0; i < NUM_STICKS; i++) begin
            raw[i] = stick_raw(f == 3 && i == 1);
         end
         raw[NUM_STICKS] = wheel_raw();
         send_frame(pack_frame(raw, 2'($urandom), 2'($urandom)), FRAME_BYTES);
      end
   endtask

   // Random frames with occasional register changes until enough traffic has passed.
   task automatic test_random_traffic();
      int frames;
      frames = 0;
      while (accepted_requests < ITEM_TARGET || reports_seen < REPORT_MIN) begin
         if (frames % 8 == 7) begin
            if ($urandom_range(0, 3) == 0) begin
               apply_setting($urandom_range(0, 1) * 2047, $urandom_range(0, 1) * 2047);
            end else begin
               apply_setting($urandom_range(0, 2047), $urandom_range(100, 900));
            end
         end
         send_random_frame();
         frames++;
      end
   endtask

   // Guard against a hung handshake.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_sweep();
      test_back_to_back();
      test_random_traffic();
      pace_on = 1'b1;
      wait_for_quiet();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/rcfd_pkg.sv
design/rcfd_frame_store.sv
design/rcfd_decode.sv
design/remote_control_frame_decoder_unit.sv
dv/tb_top.sv
